/* hw/rtl/cordic_cart_to_polar_unit_assert.svh */
// Assertion macros shared by the CORDIC polar converter.
`ifndef CORDIC_CART_TO_POLAR_UNIT_ASSERT_SVH
`define CORDIC_CART_TO_POLAR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define CC2P_ASSERT(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define CC2P_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`else
`define CC2P_ASSERT(label, clk, rst, expr, msg)
`define CC2P_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`endif

`endif

/* hw/rtl/cc2p_pkg.sv */
`default_nettype none
package cc2p_pkg;

  localparam int TAB_LEN  = 20;
  localparam int TAB_FRAC = 32;
  localparam int IO_FRAC  = 13;

  localparam logic signed [15:0] UNIT_ONE = 16'sd8192;
  localparam logic signed [15:0] SAT_MAX  = 16'sd32767;
  localparam logic signed [15:0] SAT_MIN  = -16'sd32768;

  // atan(2^-i), 32 fraction bits
  localparam logic [63:0] ATAN_TAB [TAB_LEN] = '{
    64'd3373259426, 64'd1991351318, 64'd1052175346, 64'd534100635, 64'd268086748,
    64'd134174063,  64'd67103403,   64'd33553749,   64'd16777131,  64'd8388597,
    64'd4194303,    64'd2097152,    64'd1048576,    64'd524288,    64'd262144,
    64'd131072,     64'd65536,      64'd32768,      64'd16384,     64'd8192
  };

  // running product of 1/sqrt(1 + 4^-i), 32 fraction bits
  localparam logic [63:0] GAIN_TAB [TAB_LEN] = '{
    64'd3037000500, 64'd2716375826, 64'd2635271635, 64'd2614921743, 64'd2609829388,
    64'd2608555990, 64'd2608237621, 64'd2608158028, 64'd2608138129, 64'd2608133155,
    64'd2608131911, 64'd2608131600, 64'd2608131522, 64'd2608131503, 64'd2608131498,
    64'd2608131497, 64'd2608131496, 64'd2608131496, 64'd2608131496, 64'd2608131496
  };

  typedef struct packed {
    logic valid;
    logic unit;
  } cc2p_ctl_t;

  // round half up from 32 fraction bits down to frac bits
  function automatic logic [63:0] round_const(logic [63:0] v, int frac);
    int s;
    s = TAB_FRAC - frac;
    return (v + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic logic [63:0] atan_fixed(int idx, int frac);
    return round_const(ATAN_TAB[idx], frac);
  endfunction

  function automatic logic [63:0] gain_fixed(int idx, int frac);
    return round_const(GAIN_TAB[idx], frac);
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/cc2p_prerot.sv */
`default_nettype none
module cc2p_prerot #(
  parameter int WF = 13,
  parameter int XW = 19,
  parameter int AW = 17
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    accept,
  input  wire logic signed [15:0]      coord_x,
  input  wire logic signed [15:0]      coord_y,
  output cc2p_pkg::cc2p_ctl_t          ctl,
  output logic signed [XW-1:0]         x,
  output logic signed [XW-1:0]         y,
  output logic signed [AW-1:0]         acc
);
  import cc2p_pkg::*;

  localparam int LSH = (WF >= IO_FRAC) ? WF - IO_FRAC : 0;
  localparam int RSH = (WF < IO_FRAC) ? IO_FRAC - WF : 0;
  localparam logic signed [AW-1:0] QUARTER = AW'(2 * atan_fixed(0, WF));

  logic signed [XW+15:0] xe;
  logic signed [XW+15:0] ye;
  logic signed [XW-1:0]  xi;
  logic signed [XW-1:0]  yi;
  cc2p_ctl_t             ctl_next;

  always_comb begin
    xe = {{XW{coord_x[15]}}, coord_x};
    ye = {{XW{coord_y[15]}}, coord_y};
    xe = (xe <<< LSH) >>> RSH;
    ye = (ye <<< LSH) >>> RSH;
    xi = xe[XW-1:0];
    yi = ye[XW-1:0];
    ctl_next.valid = accept;
    ctl_next.unit  = (coord_x == UNIT_ONE) && (coord_y == 16'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_next;
    end
  end

  // quarter turn into the right half plane, accumulator records the same turn
  always_ff @(posedge clk) begin
    if (coord_y[15]) begin
      x   <= -yi;
      y   <= xi;
      acc <= QUARTER;
    end else begin
      x   <= yi;
      y   <= -xi;
      acc <= -QUARTER;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/cc2p_cell.sv */
`default_nettype none
module cc2p_cell #(
  parameter int                    XW    = 19,
  parameter int                    AW    = 17,
  parameter int                    SHIFT = 0,
  parameter logic signed [AW-1:0]  ATAN  = '0
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cc2p_pkg::cc2p_ctl_t     ctl_in,
  input  wire logic signed [XW-1:0]    x_in,
  input  wire logic signed [XW-1:0]    y_in,
  input  wire logic signed [AW-1:0]    acc_in,
  output cc2p_pkg::cc2p_ctl_t          ctl_out,
  output logic signed [XW-1:0]         x_out,
  output logic signed [XW-1:0]         y_out,
  output logic signed [AW-1:0]         acc_out
);
  import cc2p_pkg::*;

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;

  assign dx = x_in >>> SHIFT;
  assign dy = y_in >>> SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  // rotate towards y = 0; y of zero counts as not positive
  always_ff @(posedge clk) begin
    if (y_in > 0) begin
      x_out   <= x_in + dy;
      y_out   <= y_in - dx;
      acc_out <= acc_in - ATAN;
    end else begin
      x_out   <= x_in - dy;
      y_out   <= y_in + dx;
      acc_out <= acc_in + ATAN;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/cc2p_post.sv */
`default_nettype none
module cc2p_post #(
  parameter int              WF   = 13,
  parameter int              XW   = 19,
  parameter int              AW   = 17,
  parameter logic [WF-1:0]   GAIN = '0
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cc2p_pkg::cc2p_ctl_t     ctl_in,
  input  wire logic signed [XW-1:0]    x_in,
  input  wire logic signed [AW-1:0]    acc_in,
  output logic                         done,
  output logic signed [15:0]           magnitude,
  output logic signed [15:0]           phase
);
  import cc2p_pkg::*;

  localparam int PW  = XW + WF + 1;
  localparam int PHW = AW + 16;
  localparam int MS  = 2 * WF - IO_FRAC;
  localparam int PL  = (WF < IO_FRAC) ? IO_FRAC - WF : 0;
  localparam int PR  = (WF > IO_FRAC) ? WF - IO_FRAC : 0;
  localparam logic signed [PW-1:0]  MAG_HALF = PW'((64'd1 << MS) >> 1);
  localparam logic signed [PHW-1:0] PH_HALF  = PHW'((64'd1 << PR) >> 1);
  localparam logic signed [PW-1:0]  MAG_HI   = PW'(32767);
  localparam logic signed [PW-1:0]  MAG_LO   = -PW'(32768);
  localparam logic signed [PHW-1:0] PH_HI    = PHW'(32767);
  localparam logic signed [PHW-1:0] PH_LO    = -PHW'(32768);

  logic signed [WF:0]     gain_s;
  logic signed [PW-1:0]   prod_next;
  logic signed [PW-1:0]   prod;
  logic signed [AW-1:0]   acc;
  cc2p_ctl_t              ctl;
  logic signed [PW-1:0]   mag_r;
  logic signed [PHW-1:0]  ph_r;
  logic signed [15:0]     magnitude_next;
  logic signed [15:0]     phase_next;

  assign gain_s    = {1'b0, GAIN};
  assign prod_next = x_in * gain_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
    acc  <= acc_in;
  end

  // round half up to 13 fraction bits, then clip to 16 bits
  always_comb begin
    mag_r = (prod + MAG_HALF) >>> MS;
    ph_r  = {{16{acc[AW-1]}}, acc};
    ph_r  = (((-ph_r) + PH_HALF) >>> PR) <<< PL;
    if (mag_r > MAG_HI) begin
      magnitude_next = SAT_MAX;
    end else if (mag_r < MAG_LO) begin
      magnitude_next = SAT_MIN;
    end else begin
      magnitude_next = mag_r[15:0];
    end
    if (ph_r > PH_HI) begin
      phase_next = SAT_MAX;
    end else if (ph_r < PH_LO) begin
      phase_next = SAT_MIN;
    end else begin
      phase_next = ph_r[15:0];
    end
    // unit point bypasses the rotation error
    if (ctl.unit) begin
      magnitude_next = UNIT_ONE;
      phase_next     = 16'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    magnitude <= magnitude_next;
    phase     <= phase_next;
  end

endmodule
`default_nettype wire

/* hw/rtl/cordic_cart_to_polar_unit.sv */
`default_nettype none
// Cartesian to polar converter, CORDIC vectoring.
// Command channel: a word (coord_x, coord_y, signed Q2.13) is taken on a rising
// edge where start is high and busy is low. busy is high only while rst is held;
// otherwise a new word may be issued every cycle.
// Result channel: done pulses for one cycle with magnitude (Q2.13, clipped to
// full scale) and phase (radians, Q2.13) valid in that same cycle. The
// receiver cannot stall; each result must be captured while done is high.
// Pipeline: the accepting edge loads the quarter-turn register, followed by
// one register per rotation cell, the gain multiplier register and the
// rounding/output register, which drives done.
// Throughput: one word per cycle outside reset (fully pipelined cell chain).
// Words in flight move through the chain in order, never stalling.
// Reset (synchronous) empties the chain: words in flight are dropped and no
// done pulse follows for them. The datapath needs no clearing.
module cordic_cart_to_polar_unit #(
  parameter int ITERATIONS = 11,
  parameter int DATA_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] coord_x,
  input  wire logic signed [15:0] coord_y,
  output logic                    done,
  output logic signed [15:0]      magnitude,
  output logic signed [15:0]      phase
);
  import cc2p_pkg::*;
  `include "cordic_cart_to_polar_unit_assert.svh"

  localparam int STEPS = (ITERATIONS > TAB_LEN) ? TAB_LEN :
                         ((ITERATIONS < 1) ? 1 : ITERATIONS);
  localparam int WF    = DATA_WIDTH - 3;
  localparam int XW    = WF + 6;
  localparam int AW    = WF + 4;
  localparam int LAT   = STEPS + 3;
  localparam logic [WF-1:0] GAIN = WF'(gain_fixed(STEPS - 1, WF));

  logic                 accept;
  cc2p_ctl_t            ctl [STEPS+1];
  logic signed [XW-1:0] xs  [STEPS+1];
  logic signed [XW-1:0] ys  [STEPS+1];
  logic signed [AW-1:0] as  [STEPS+1];

  assign busy   = rst;
  assign accept = start && !busy;

  cc2p_prerot #(.WF(WF), .XW(XW), .AW(AW)) u_prerot (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .coord_x (coord_x),
    .coord_y (coord_y),
    .ctl     (ctl[0]),
    .x       (xs[0]),
    .y       (ys[0]),
    .acc     (as[0])
  );

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    cc2p_cell #(
      .XW    (XW),
      .AW    (AW),
      .SHIFT (i),
      .ATAN  (AW'(atan_fixed(i, WF)))
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl[i]),
      .x_in    (xs[i]),
      .y_in    (ys[i]),
      .acc_in  (as[i]),
      .ctl_out (ctl[i+1]),
      .x_out   (xs[i+1]),
      .y_out   (ys[i+1]),
      .acc_out (as[i+1])
    );
  end

  cc2p_post #(.WF(WF), .XW(XW), .AW(AW), .GAIN(GAIN)) u_post (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (ctl[STEPS]),
    .x_in      (xs[STEPS]),
    .acc_in    (as[STEPS]),
    .done      (done),
    .magnitude (magnitude),
    .phase     (phase)
  );

  `CC2P_ASSERT_IMP(a_done_has_word, clk, rst, done, $past(accept, LAT),
    "done without a word accepted LAT cycles earlier")
  `CC2P_ASSERT_IMP(a_unit_exact, clk, rst,
    done && $past(accept && coord_x == UNIT_ONE && coord_y == 16'sd0, LAT),
    magnitude == UNIT_ONE && phase == 16'sd0, "unit point not exact")
  `CC2P_ASSERT_IMP(a_origin_zero, clk, rst,
    done && $past(accept && coord_x == 16'sd0 && coord_y == 16'sd0, LAT),
    magnitude == 16'sd0, "origin gives non-zero magnitude")

endmodule
`default_nettype wire
